/* design/ped_pkg.sv */
// Shared types and constants for the polygon edge subdivider.
package ped_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int CFG_W            = 31;
    localparam int QUEUE_DEPTH      = 2;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sub;
        logic               orig;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_LCHK,
        ST_NSEG,
        ST_NSET,
        ST_DIV,
        ST_EMIT,
        ST_VERT
    } t_bstate;

endpackage

/* design/ped_front.sv */
// Front end: accepts requests, tracks contour state, builds edge jobs.
module ped_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic              i_full,
    output logic              o_push,
    output ped_pkg::t_job     o_job
);
    import ped_pkg::*;

    logic signed [31:0] r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic signed [31:0] n_prev_x, n_prev_y, n_first_x, n_first_y;
    logic               r_have, n_have;
    logic               acc;
    logic signed [31:0] bx, by;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        bx = i_func ? r_first_x : i_point_x;
        by = i_func ? r_first_y : i_point_y;
        o_job.ax   = r_prev_x;
        o_job.ay   = r_prev_y;
        o_job.vx   = bx;
        o_job.vy   = by;
        o_job.dx   = $signed({bx[31], bx}) - $signed({r_prev_x[31], r_prev_x});
        o_job.dy   = $signed({by[31], by}) - $signed({r_prev_y[31], r_prev_y});
        o_job.sub  = i_func ? 1'b1 : r_have;
        o_job.orig = !i_func;
        o_push     = acc && (!i_func || r_have);
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_have    = r_have;
        if (acc) begin
            if (!i_func) begin
                n_prev_x = i_point_x;
                n_prev_y = i_point_y;
                if (!r_have) begin
                    n_first_x = i_point_x;
                    n_first_y = i_point_y;
                    n_have    = 1'b1;
                end
            end else if (r_have) begin
                n_prev_x  = '0;
                n_prev_y  = '0;
                n_first_x = '0;
                n_first_y = '0;
                n_have    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_have    <= 1'b0;
        end else begin
            r_prev_x  <= n_prev_x;
            r_prev_y  <= n_prev_y;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
            r_have    <= n_have;
        end
    end

endmodule

/* design/ped_queue.sv */
// Short job queue between front and back.
module ped_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ped_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ped_pkg::t_job o_job
);
    import ped_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

/* design/ped_back.sv */
// Back end: edge length, segment count, step division and point output.
module ped_back #(
    parameter int MAX_SEGMENTS = ped_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ped_pkg::CFG_W-1:0]  i_max_len,
    input  logic                       i_empty,
    input  ped_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_out_x,
    output logic signed [31:0]         o_out_y,
    output logic                       o_is_original,
    output logic                       o_last_of_run
);
    import ped_pkg::*;

    localparam int NB   = $clog2(MAX_SEGMENTS) + 1;
    localparam int DW   = CFG_W + NB;
    localparam int CMPW = (DW > 34) ? DW : 34;

    t_bstate r_state, n_state;
    t_job    r_job, n_job;

    logic [65:0]        r_s, n_s;
    logic [67:0]        r_sh, n_sh;
    logic [35:0]        r_rem, n_rem;
    logic [33:0]        r_root, n_root;
    logic [5:0]         r_cnt, n_cnt;
    logic [DW-1:0]      r_dsh, n_dsh;
    logic [NB:0]        r_q, n_q;
    logic [NB-1:0]      r_nseg, n_nseg;
    logic [32:0]        r_nx, n_nx, r_ny, n_ny;
    logic [NB-1:0]      r_rx, n_rx, r_ry, n_ry;
    logic [32:0]        r_accx, n_accx, r_accy, n_accy;
    logic [NB-1:0]      r_arx, n_arx, r_ary, n_ary;
    logic [NB-1:0]      r_k, n_k;

    logic               r_ov, n_ov;
    logic signed [31:0] r_ox, n_ox, r_oy, n_oy;
    logic               r_oo, n_oo, r_ol, n_ol;

    logic [32:0]        mx, my, mul_a;
    logic [65:0]        prod;
    logic [37:0]        rem_sh, trial;
    logic [CMPW-1:0]    ncmp_a, ncmp_b;
    logic [NB:0]        dvx, dvy, tx, ty;
    logic [33:0]        px, py;
    logic               o_en;

    assign mx    = r_job.dx[32] ? (~r_job.dx + 33'd1) : r_job.dx;
    assign my    = r_job.dy[32] ? (~r_job.dy + 33'd1) : r_job.dy;
    assign mul_a = (r_state == ST_SQX) ? mx : my;
    assign prod  = mul_a * mul_a;
    assign o_en  = !r_ov || !i_stall;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_s     = r_s;
        n_sh    = r_sh;
        n_rem   = r_rem;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_nseg  = r_nseg;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_accx  = r_accx;
        n_accy  = r_accy;
        n_arx   = r_arx;
        n_ary   = r_ary;
        n_k     = r_k;
        n_ov    = r_ov && i_stall;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_oo    = r_oo;
        n_ol    = r_ol;
        o_pop   = 1'b0;
        rem_sh  = {r_rem, r_sh[67:66]};
        trial   = {2'b00, r_root, 2'b01};
        ncmp_a  = CMPW'(r_root);
        ncmp_b  = CMPW'(r_dsh);
        dvx     = {r_rx, r_nx[32]};
        dvy     = {r_ry, r_ny[32]};
        tx      = {1'b0, r_arx} + {1'b0, r_rx};
        ty      = {1'b0, r_ary} + {1'b0, r_ry};
        px      = {{2{r_job.ax[31]}}, r_job.ax}
                  + (r_job.dx[32] ? (~{1'b0, r_accx} + 34'd1) : {1'b0, r_accx});
        py      = {{2{r_job.ay[31]}}, r_job.ay}
                  + (r_job.dy[32] ? (~{1'b0, r_accy} + 34'd1) : {1'b0, r_accy});
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    if (i_job.sub && (i_max_len != '0)) begin
                        n_state = ST_SQX;
                    end else if (i_job.orig) begin
                        n_state = ST_VERT;
                    end
                end
            end
            ST_SQX: begin
                n_s     = prod;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_sh    = {2'b00, r_s + prod};
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = 6'd33;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                n_sh = {r_sh[65:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = 36'(rem_sh - trial);
                    n_root = {r_root[32:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[35:0];
                    n_root = {r_root[32:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = ST_LCHK;
                end
            end
            ST_LCHK: begin
                if (r_root <= {3'b000, i_max_len}) begin
                    n_state = r_job.orig ? ST_VERT : ST_IDLE;
                end else begin
                    n_dsh   = {i_max_len, {NB{1'b0}}};
                    n_q     = '0;
                    n_cnt   = 6'(NB);
                    n_state = ST_NSEG;
                end
            end
            ST_NSEG: begin
                if (ncmp_a >= ncmp_b) begin
                    n_root = 34'(ncmp_a - ncmp_b);
                    n_q    = {r_q[NB-1:0], 1'b1};
                end else begin
                    n_q    = {r_q[NB-1:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = ST_NSET;
                end
            end
            ST_NSET: begin
                n_nseg = (r_q > (NB+1)'(MAX_SEGMENTS)) ? NB'(MAX_SEGMENTS) : r_q[NB-1:0];
                if ((r_q < (NB+1)'(2))) begin
                    n_state = r_job.orig ? ST_VERT : ST_IDLE;
                end else begin
                    n_nx    = mx;
                    n_ny    = my;
                    n_rx    = '0;
                    n_ry    = '0;
                    n_cnt   = 6'd32;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dvx >= {1'b0, r_nseg}) begin
                    n_rx = NB'(dvx - {1'b0, r_nseg});
                    n_nx = {r_nx[31:0], 1'b1};
                end else begin
                    n_rx = dvx[NB-1:0];
                    n_nx = {r_nx[31:0], 1'b0};
                end
                if (dvy >= {1'b0, r_nseg}) begin
                    n_ry = NB'(dvy - {1'b0, r_nseg});
                    n_ny = {r_ny[31:0], 1'b1};
                end else begin
                    n_ry = dvy[NB-1:0];
                    n_ny = {r_ny[31:0], 1'b0};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_accx  = n_nx;
                    n_accy  = n_ny;
                    n_arx   = n_rx;
                    n_ary   = n_ry;
                    n_k     = NB'(1);
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_en) begin
                    n_ov = 1'b1;
                    n_ox = px[31:0];
                    n_oy = py[31:0];
                    n_oo = 1'b0;
                    n_ol = (r_k == r_nseg - NB'(1)) && !r_job.orig;
                    if (tx >= {1'b0, r_nseg}) begin
                        n_arx  = NB'(tx - {1'b0, r_nseg});
                        n_accx = r_accx + r_nx + 33'd1;
                    end else begin
                        n_arx  = tx[NB-1:0];
                        n_accx = r_accx + r_nx;
                    end
                    if (ty >= {1'b0, r_nseg}) begin
                        n_ary  = NB'(ty - {1'b0, r_nseg});
                        n_accy = r_accy + r_ny + 33'd1;
                    end else begin
                        n_ary  = ty[NB-1:0];
                        n_accy = r_accy + r_ny;
                    end
                    n_k = r_k + NB'(1);
                    if (r_k == r_nseg - NB'(1)) begin
                        n_state = r_job.orig ? ST_VERT : ST_IDLE;
                    end
                end
            end
            ST_VERT: begin
                if (o_en) begin
                    n_ov    = 1'b1;
                    n_ox    = r_job.vx;
                    n_oy    = r_job.vy;
                    n_oo    = 1'b1;
                    n_ol    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_s    <= n_s;
        r_sh   <= n_sh;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_nseg <= n_nseg;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_accx <= n_accx;
        r_accy <= n_accy;
        r_arx  <= n_arx;
        r_ary  <= n_ary;
        r_k    <= n_k;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oo   <= n_oo;
        r_ol   <= n_ol;
    end

    assign o_valid       = r_ov;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_is_original = r_oo;
    assign o_last_of_run = r_ol;

    a_emit_nseg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_nseg >= NB'(2) && r_k < r_nseg))
        else $error("interior point outside segment range");
    a_vert_orig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VERT) |-> r_job.orig)
        else $error("vertex output for a close request");
    a_orig_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oo) |-> r_ol)
        else $error("original vertex not last of its run");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && !i_empty))
        else $error("job taken outside idle");

endmodule

/* design/polygon_edge_subdivider.sv */
// Top level of the polygon edge subdivider.
//  channel  | handshake          | payload
//  request  | i_valid / o_stall  | i_func, i_point_x, i_point_y
//  result   | o_valid / i_stall  | o_out_x, o_out_y, o_is_original, o_last_of_run
//  config   | i_cfg_we           | i_cfg_data (max_len)
// Edge job: take, square x and y, bit-serial root, length check, segment count division and
// set, step division by two serial dividers (x and y side by side), then one emitted point
// per cycle while the result side does not stall. A vertex with no edge to split goes from
// the take straight to its output. A new job is taken only in idle, after the last output.
// Front takes requests while the two-entry job queue has room.
// Synchronous active-low reset clears contour state, queue and output valid.
module polygon_edge_subdivider #(
    parameter int MAX_SEGMENTS = ped_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ped_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_func,
    input  logic signed [31:0]        i_point_x,
    input  logic signed [31:0]        i_point_y,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [31:0]        o_out_x,
    output logic signed [31:0]        o_out_y,
    output logic                      o_is_original,
    output logic                      o_last_of_run
);
    import ped_pkg::*;

    logic [CFG_W-1:0] r_max_len;
    t_job             push_job, head_job;
    logic             push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= '0;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    ped_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    ped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    ped_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_len     (r_max_len),
        .i_empty       (empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_is_original (o_is_original),
        .o_last_of_run (o_last_of_run)
    );

endmodule
